// File: rtl/upe_pkg.sv
`timescale 1ns / 1ps

package upe_pkg;

    localparam logic [15:0] CH_BANG   = 16'h0021;
    localparam logic [15:0] CH_DASH   = 16'h002D;
    localparam logic [15:0] CH_DOT    = 16'h002E;
    localparam logic [15:0] CH_UNDER  = 16'h005F;
    localparam logic [15:0] CH_TILDE  = 16'h007E;
    localparam logic [15:0] CH_QUOTE  = 16'h0027;
    localparam logic [15:0] CH_STAR   = 16'h002A;
    localparam logic [15:0] CH_ZERO   = 16'h0030;
    localparam logic [15:0] CH_COLON  = 16'h003A;
    localparam logic [15:0] CH_UC_A   = 16'h0041;
    localparam logic [15:0] CH_UC_Z   = 16'h005A;
    localparam logic [15:0] CH_LC_A   = 16'h0061;
    localparam logic [15:0] CH_LC_Z   = 16'h007A;
    localparam logic [15:0] ONE_BYTE_LIM = 16'h0080;
    localparam logic [15:0] TWO_BYTE_LIM = 16'h0800;
    localparam logic [15:0] SURR_LO   = 16'hD800;
    localparam logic [15:0] SURR_HI   = 16'hE000;
    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [6:0]  CH_PCT    = 7'h25;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic            pass;
        logic [1:0]      nbytes_m1;
        logic [3:0][7:0] bytes;
        logic            last;
    } t_job;

    typedef enum logic [1:0] {
        PH_PCT,
        PH_HI,
        PH_LO
    } t_phase;

    function automatic logic is_safe(input logic [15:0] c);
        return c == CH_BANG || c == CH_DASH || c == CH_DOT || c == CH_UNDER ||
               c == CH_TILDE ||
               (c >= CH_QUOTE && c <= CH_STAR) ||
               (c >= CH_ZERO && c <= CH_COLON) ||
               (c >= CH_UC_A && c <= CH_UC_Z) ||
               (c >= CH_LC_A && c <= CH_LC_Z);
    endfunction

    function automatic logic [6:0] hex_char(input logic [3:0] d);
        return (d < 4'd10) ? (7'h30 + {3'b000, d}) : (7'h37 + {3'b000, d});
    endfunction

endpackage

// File: rtl/upe_in_if.sv
`timescale 1ns / 1ps

interface upe_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last_unit;

    modport source (output valid, output code_unit, output last_unit, input ready);
    modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

// File: rtl/upe_out_if.sv
`timescale 1ns / 1ps

interface upe_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       run_last;
    logic       string_end;

    modport source (output valid, output out_char, output run_last, output string_end,
                    input ready);
    modport sink   (input valid, input out_char, input run_last, input string_end,
                    output ready);
endinterface

// File: rtl/utf16_percent_encoder.sv
`timescale 1ns / 1ps
// An accepted item passes through the job queue and the back-end job register before
// its first character is registered. One output character per cycle while the output
// is ready; an item makes 1, 3, 6, 9 or 12 characters and a held surrogate makes none.
// Input is taken every cycle while the job queue has room (QUEUE_DEPTH entries).
// Reset (i_rst_n low, synchronous) drops any held surrogate, queued jobs and output.

module utf16_percent_encoder #(
    parameter int QUEUE_DEPTH = upe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    upe_in_if.sink    i_in,
    upe_out_if.source o_out
);
    import upe_pkg::*;

    logic push;
    t_job push_job;
    logic full;
    logic q_valid;
    t_job q_job;
    logic pop;

    upe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    upe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    upe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// File: rtl/upe_front.sv
`timescale 1ns / 1ps

module upe_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    upe_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output upe_pkg::t_job o_job
);
    import upe_pkg::*;

    logic        r_lead_pending;
    logic [9:0]  r_lead_bits;
    logic        n_lead_pending;
    logic [9:0]  n_lead_bits;
    logic [15:0] c;
    logic        is_sur;
    logic        four;
    logic        hold;
    logic        acc;
    logic [19:0] base;
    logic [20:0] cp;

    assign c      = i_in.code_unit;
    assign is_sur = (c >= SURR_LO) && (c < SURR_HI);
    assign four   = r_lead_pending || (is_sur && i_in.last_unit);
    assign hold   = !r_lead_pending && is_sur && !i_in.last_unit;
    assign acc    = i_in.valid && i_in.ready;
    assign base   = r_lead_pending ? {r_lead_bits, c[9:0]} : {c[9:0], 10'b0};
    assign cp     = SUPP_BASE + {1'b0, base};

    assign i_in.ready = !i_full;
    assign o_push     = acc && !hold;

    always_comb begin
        o_job           = '0;
        o_job.last      = i_in.last_unit;
        if (four) begin
            o_job.nbytes_m1 = 2'd3;
            o_job.bytes[0]  = {5'b11110, cp[20:18]};
            o_job.bytes[1]  = {2'b10, cp[17:12]};
            o_job.bytes[2]  = {2'b10, cp[11:6]};
            o_job.bytes[3]  = {2'b10, cp[5:0]};
        end else if (is_safe(c)) begin
            o_job.pass      = 1'b1;
            o_job.bytes[0]  = c[7:0];
        end else if (c < ONE_BYTE_LIM) begin
            o_job.nbytes_m1 = 2'd0;
            o_job.bytes[0]  = c[7:0];
        end else if (c < TWO_BYTE_LIM) begin
            o_job.nbytes_m1 = 2'd1;
            o_job.bytes[0]  = {3'b110, c[10:6]};
            o_job.bytes[1]  = {2'b10, c[5:0]};
        end else begin
            o_job.nbytes_m1 = 2'd2;
            o_job.bytes[0]  = {4'b1110, c[15:12]};
            o_job.bytes[1]  = {2'b10, c[11:6]};
            o_job.bytes[2]  = {2'b10, c[5:0]};
        end
    end

    always_comb begin
        n_lead_pending = r_lead_pending;
        n_lead_bits    = r_lead_bits;
        if (acc) begin
            n_lead_pending = hold;
            n_lead_bits    = hold ? c[9:0] : 10'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_pending <= 1'b0;
            r_lead_bits    <= '0;
        end else begin
            r_lead_pending <= n_lead_pending;
            r_lead_bits    <= n_lead_bits;
        end
    end

`ifndef SYNTHESIS
    a_pair_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_lead_pending) |=> !r_lead_pending)
        else $error("held surrogate not released on pairing word");
    a_hold_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && hold) |-> !o_push)
        else $error("held surrogate pushed a job");
`endif

endmodule

// File: rtl/upe_queue.sv
`timescale 1ns / 1ps

module upe_queue #(
    parameter int DEPTH = upe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  upe_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output upe_pkg::t_job o_job,
    input  logic          i_pop
);
    import upe_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CW'(do_push) - CW'(do_pop);
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// File: rtl/upe_back.sv
`timescale 1ns / 1ps

module upe_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  upe_pkg::t_job i_job,
    output logic          o_pop,
    upe_out_if.source     o_out
);
    import upe_pkg::*;

    t_phase     r_phase;
    t_phase     n_phase;
    logic       r_busy;
    logic       n_busy;
    t_job       r_job;
    t_job       n_job;
    logic [1:0] r_byte;
    logic [1:0] n_byte;
    logic       r_ov;
    logic       n_ov;
    logic [6:0] r_char;
    logic [6:0] n_char;
    logic       r_rl;
    logic       n_rl;
    logic       r_se;
    logic       n_se;
    logic       advance;
    logic       final_ch;
    logic [7:0] cur_byte;

    assign o_out.valid      = r_ov;
    assign o_out.out_char   = r_char;
    assign o_out.run_last   = r_rl;
    assign o_out.string_end = r_se;

    assign cur_byte = r_job.bytes[r_byte];
    assign advance  = r_busy && (!r_ov || o_out.ready);
    assign final_ch = r_job.pass || (r_phase == PH_LO && r_byte == r_job.nbytes_m1);
    assign o_pop    = i_valid && (!r_busy || (advance && final_ch));

    always_comb begin
        n_phase = r_phase;
        n_busy  = r_busy;
        n_job   = r_job;
        n_byte  = r_byte;
        n_ov    = r_ov && !o_out.ready;
        n_char  = r_char;
        n_rl    = r_rl;
        n_se    = r_se;
        if (advance) begin
            n_ov = 1'b1;
            n_rl = final_ch;
            n_se = final_ch && r_job.last;
            if (r_job.pass) begin
                n_char = r_job.bytes[0][6:0];
            end else begin
                case (r_phase)
                    PH_PCT: begin
                        n_char  = CH_PCT;
                        n_phase = PH_HI;
                    end
                    PH_HI: begin
                        n_char  = hex_char(cur_byte[7:4]);
                        n_phase = PH_LO;
                    end
                    PH_LO: begin
                        n_char  = hex_char(cur_byte[3:0]);
                        n_phase = PH_PCT;
                        n_byte  = r_byte + 2'd1;
                    end
                    default: begin
                        n_char  = CH_PCT;
                        n_phase = PH_PCT;
                    end
                endcase
            end
            if (final_ch) begin
                n_busy = 1'b0;
            end
        end
        if (o_pop) begin
            n_busy  = 1'b1;
            n_job   = i_job;
            n_byte  = '0;
            n_phase = PH_PCT;
        end
    end

    always_ff @(posedge i_clk) begin
        n_job_reg: begin
            r_job  <= n_job;
            r_byte <= n_byte;
            r_char <= n_char;
            r_rl   <= n_rl;
            r_se   <= n_se;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PCT;
            r_busy  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_busy  <= n_busy;
            r_ov    <= n_ov;
        end
    end

`ifndef SYNTHESIS
    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_se) |-> r_rl)
        else $error("string end without run end");
    a_pass_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_job.pass) |-> (r_phase == PH_PCT))
        else $error("pass-through word left escape phase");
`endif

endmodule
